@@ rtl/core/svm_pkg.sv @@
package svm_pkg;

    // Widths of the sample path.
    localparam int SAMPLE_BITS  = 12;
    localparam int FILTER_SHIFT = 3;
    localparam int FRAC_BITS    = 8;
    localparam int ACC_W        = SAMPLE_BITS + FRAC_BITS;

    // Widths of the configuration registers.
    localparam int REF_W = 13;
    localparam int FS_W  = 16;
    localparam int OHM_W = 20;
    localparam int CFG_W = 20;

    // Widths of the shared multiplier and of the shared divider.
    localparam int MUL_A_W = SAMPLE_BITS + REF_W;
    localparam int MUL_B_W = OHM_W + 1;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int DEN_W   = FS_W + OHM_W;
    localparam int DVD_W   = PROD_W + 1;
    localparam int PIN_DVD_W = MUL_A_W + 1;
    localparam int CNT_W   = 6;

    // Register indexes of the configuration port.
    localparam logic [1:0] REG_REFERENCE_MV = 2'd0;
    localparam logic [1:0] REG_FULL_SCALE   = 2'd1;
    localparam logic [1:0] REG_DIV_TOP      = 2'd2;
    localparam logic [1:0] REG_DIV_BOTTOM   = 2'd3;

    // Reset values of the configuration registers.
    localparam logic [REF_W-1:0] RESET_REF_MV  = 13'd3300;
    localparam logic [FS_W-1:0]  RESET_FS      = 16'd4095;
    localparam logic [OHM_W-1:0] RESET_TOP     = 20'd100000;
    localparam logic [OHM_W-1:0] RESET_BOTTOM  = 20'd10000;

    // Input word kinds carried on s_tuser.
    localparam logic FUNC_SAMPLE  = 1'b0;
    localparam logic FUNC_TIMEOUT = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FILT,
        ST_ROUND,
        ST_MUL_A,
        ST_MUL_B,
        ST_MUL_C,
        ST_LOAD_PIN,
        ST_DIV_PIN,
        ST_LOAD_BAT,
        ST_DIV_BAT,
        ST_DONE
    } state_t;

endpackage

@@ rtl/core/supply_voltage_monitor.sv @@
// Channel   Direction  Signals                          Contents
// s_axis    in         s_tvalid s_tready s_tdata s_tuser one ADC event
// m_axis    out        m_tvalid m_tready m_tdata m_tuser one status report
// cfg       in         cfg_we cfg_index cfg_wdata        register write
//
// A timeout word goes straight to the report state; a sample word first passes through the
// filter update, three products on one shared multiplier, then one restoring divider
// at one quotient bit per cycle, 26 steps for pin and 47 for battery millivolts.
// s_tready is high only while the sequencer is idle; a finished report waits
// in the output register and the next word can be accepted meanwhile.
// Reset is asynchronous and active low; it restores all registers.
module supply_voltage_monitor
    import svm_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [15:0]        s_tdata,   // [11:0] raw_sample
    input  logic               s_tuser,   // [0] func
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [167:0]       m_tdata,   // [11:0] sample_out, [23:12] filtered_value,
                                          // [39:24] pin_millivolts,
                                          // [71:40] battery_millivolts,
                                          // [103:72] samples_taken,
                                          // [135:104] timeouts_seen,
                                          // [151:136] lowest_raw,
                                          // [163:152] highest_raw
    output logic               m_tuser,   // [0] ok
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [CFG_W-1:0]   cfg_wdata
);

    state_t state_reg, state_next;

    // Configuration.
    logic [REF_W-1:0] ref_mv_reg;
    logic [FS_W-1:0]  fs_reg;
    logic [OHM_W-1:0] top_reg;
    logic [OHM_W-1:0] bot_reg;

    // Monitor state.
    logic [ACC_W-1:0]       acc_reg;
    logic [15:0]            min_reg;
    logic [SAMPLE_BITS-1:0] max_reg;
    logic [31:0]            sample_cnt_reg;
    logic [31:0]            timeout_cnt_reg;
    logic [15:0]            pin_reg;
    logic [31:0]            bat_reg;
    logic [SAMPLE_BITS-1:0] filt_reg;

    // Per-word working registers.
    logic [SAMPLE_BITS-1:0] raw_reg;
    logic                   is_sample_reg;
    logic [MUL_A_W-1:0]     p1_reg;
    logic [PROD_W-1:0]      pbat_reg;
    logic [DEN_W-1:0]       den_bat_reg;

    // Shared divider.
    logic [DVD_W-1:0] quo_reg, quo_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [DEN_W-1:0] dvs_reg;
    logic [CNT_W-1:0] cnt_reg;

    // Output register.
    logic         m_tvalid_reg;
    logic [167:0] m_tdata_reg;
    logic         m_tuser_reg;

    logic s_accept;
    logic out_load;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // Zero full scale and zero bottom resistor behave as one.
    logic [FS_W-1:0]  fs_eff;
    logic [OHM_W-1:0] bot_eff;
    assign fs_eff  = (fs_reg  == '0) ? FS_W'(1)  : fs_reg;
    assign bot_eff = (bot_reg == '0) ? OHM_W'(1) : bot_reg;

    // Filter update: move the accumulator toward the target by a truncated
    // fraction of the error magnitude.
    logic [ACC_W-1:0] target;
    logic [ACC_W:0]   err;
    logic             err_ge;
    logic [ACC_W-1:0] err_mag;
    logic [ACC_W-1:0] step;
    logic [ACC_W-1:0] acc_upd;
    logic [ACC_W:0]   acc_round;
    always_comb
    begin
        target  = {raw_reg, {FRAC_BITS{1'b0}}};
        err     = {1'b0, target} - {1'b0, acc_reg};
        err_ge  = !err[ACC_W];
        err_mag = err_ge ? err[ACC_W-1:0] : (~err[ACC_W-1:0] + ACC_W'(1));
        step    = err_mag >> FILTER_SHIFT;
        acc_upd = err_ge ? (acc_reg + step) : (acc_reg - step);
        acc_round = {1'b0, acc_reg} + (ACC_W+1)'(1 << (FRAC_BITS - 1));
    end

    // Shared multiplier with operands chosen by the sequencer.
    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;
    logic [PROD_W-1:0]  prod;
    always_comb
    begin
        case (state_reg)
            ST_MUL_A:
            begin
                mul_a = MUL_A_W'(filt_reg);
                mul_b = MUL_B_W'(ref_mv_reg);
            end
            ST_MUL_B:
            begin
                mul_a = p1_reg;
                mul_b = {1'b0, top_reg} + {1'b0, bot_eff};
            end
            ST_MUL_C:
            begin
                mul_a = MUL_A_W'(fs_eff);
                mul_b = MUL_B_W'(bot_eff);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        prod = PROD_W'(mul_a) * PROD_W'(mul_b);
    end

    // Shared restoring divider step: one quotient bit per cycle.
    logic [DEN_W:0] trial;
    logic [DEN_W:0] trial_diff;
    logic           q_bit;
    always_comb
    begin
        trial      = {rem_reg, quo_reg[DVD_W-1]};
        trial_diff = trial - {1'b0, dvs_reg};
        q_bit      = !trial_diff[DEN_W];
        rem_next   = q_bit ? trial_diff[DEN_W-1:0] : trial[DEN_W-1:0];
        quo_next   = {quo_reg[DVD_W-2:0], q_bit};
    end

    // Rounding dividends.
    logic [PIN_DVD_W-1:0] pin_dvd;
    logic [DVD_W-1:0]     bat_dvd;
    assign pin_dvd = {1'b0, p1_reg} + PIN_DVD_W'(fs_eff >> 1);
    assign bat_dvd = {1'b0, pbat_reg} + DVD_W'(den_bat_reg >> 1);

    // Sequencer next state.
    always_comb
    begin
        state_next = state_reg;
        out_load   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_accept)
                begin
                    state_next = (s_tuser == FUNC_TIMEOUT) ? ST_DONE : ST_FILT;
                end
            end
            ST_FILT:     state_next = ST_ROUND;
            ST_ROUND:    state_next = ST_MUL_A;
            ST_MUL_A:    state_next = ST_MUL_B;
            ST_MUL_B:    state_next = ST_MUL_C;
            ST_MUL_C:    state_next = ST_LOAD_PIN;
            ST_LOAD_PIN: state_next = ST_DIV_PIN;
            ST_DIV_PIN:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = ST_LOAD_BAT;
                end
            end
            ST_LOAD_BAT: state_next = ST_DIV_BAT;
            ST_DIV_BAT:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Configuration registers; values are masked to their widths.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_mv_reg <= RESET_REF_MV;
            fs_reg     <= RESET_FS;
            top_reg    <= RESET_TOP;
            bot_reg    <= RESET_BOTTOM;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_REFERENCE_MV: ref_mv_reg <= cfg_wdata[REF_W-1:0];
                REG_FULL_SCALE:   fs_reg     <= cfg_wdata[FS_W-1:0];
                REG_DIV_TOP:      top_reg    <= cfg_wdata[OHM_W-1:0];
                REG_DIV_BOTTOM:   bot_reg    <= cfg_wdata[OHM_W-1:0];
                default:          ;
            endcase
        end
    end

    // Monitor state: counters, filter, extremes and last scaled results.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg         <= '0;
            min_reg         <= 16'hFFFF;
            max_reg         <= '0;
            sample_cnt_reg  <= '0;
            timeout_cnt_reg <= '0;
            pin_reg         <= '0;
            bat_reg         <= '0;
            filt_reg        <= '0;
            raw_reg         <= '0;
            is_sample_reg   <= 1'b0;
        end
        else
        begin
            if (s_accept)
            begin
                raw_reg       <= s_tdata[SAMPLE_BITS-1:0];
                is_sample_reg <= (s_tuser == FUNC_SAMPLE);
                if (s_tuser == FUNC_TIMEOUT)
                begin
                    timeout_cnt_reg <= timeout_cnt_reg + 32'd1;
                end
            end
            if (state_reg == ST_FILT)
            begin
                // The first sample after reset or after a count wrap seeds.
                if (sample_cnt_reg == '0)
                begin
                    acc_reg <= target;
                    min_reg <= 16'(raw_reg);
                    max_reg <= raw_reg;
                end
                else
                begin
                    acc_reg <= acc_upd;
                    if (16'(raw_reg) < min_reg)
                    begin
                        min_reg <= 16'(raw_reg);
                    end
                    if (raw_reg > max_reg)
                    begin
                        max_reg <= raw_reg;
                    end
                end
                sample_cnt_reg <= sample_cnt_reg + 32'd1;
            end
            if (state_reg == ST_ROUND)
            begin
                filt_reg <= acc_round[ACC_W-1:FRAC_BITS];
            end
            if ((state_reg == ST_DIV_PIN) && (cnt_reg == '0))
            begin
                pin_reg <= quo_next[15:0];
            end
            if ((state_reg == ST_DIV_BAT) && (cnt_reg == '0))
            begin
                bat_reg <= quo_next[31:0];
            end
        end
    end

    // Products and divider datapath.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_reg      <= '0;
            pbat_reg    <= '0;
            den_bat_reg <= '0;
        end
        else
        begin
            case (state_reg)
                ST_MUL_A: p1_reg      <= prod[MUL_A_W-1:0];
                ST_MUL_B: pbat_reg    <= prod;
                ST_MUL_C: den_bat_reg <= prod[DEN_W-1:0];
                default:  ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quo_reg <= '0;
            rem_reg <= '0;
            dvs_reg <= DEN_W'(1);
            cnt_reg <= '0;
        end
        else
        begin
            case (state_reg)
                ST_LOAD_PIN:
                begin
                    // Dividend sits in the top bits so that its quotient
                    // lands in the low bits after its own number of steps.
                    quo_reg <= {pin_dvd, {(DVD_W - PIN_DVD_W){1'b0}}};
                    rem_reg <= '0;
                    dvs_reg <= DEN_W'(fs_eff);
                    cnt_reg <= CNT_W'(PIN_DVD_W - 1);
                end
                ST_LOAD_BAT:
                begin
                    quo_reg <= bat_dvd;
                    rem_reg <= '0;
                    dvs_reg <= den_bat_reg;
                    cnt_reg <= CNT_W'(DVD_W - 1);
                end
                ST_DIV_PIN, ST_DIV_BAT:
                begin
                    quo_reg <= quo_next;
                    rem_reg <= rem_next;
                    cnt_reg <= cnt_reg - CNT_W'(1);
                end
                default: ;
            endcase
        end
    end

    // Output register holding one report word.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tuser_reg <= 1'b0;
            m_tdata_reg <= '0;
        end
        else if (out_load)
        begin
            m_tuser_reg <= is_sample_reg;
            m_tdata_reg <= {4'b0, max_reg, min_reg, timeout_cnt_reg, sample_cnt_reg,
                            bat_reg, pin_reg, filt_reg,
                            is_sample_reg ? raw_reg : {SAMPLE_BITS{1'b0}}};
        end
    end

    // The block is busy in the cycle after it takes a word.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_accept |=> !s_tready)
        else $error("input taken while a word is still in work");

    // A timeout report carries a zero sample.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser) |-> (m_tdata[11:0] == 12'd0))
        else $error("timeout report with nonzero sample");

    // The partial remainder stays below the divisor during a division.
    assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_DIV_PIN) || (state_reg == ST_DIV_BAT)) |-> (rem_reg < dvs_reg))
        else $error("divider remainder out of range");

    // Once seeded, the minimum never exceeds the maximum.
    assert property (@(posedge clk) disable iff (!rst_n)
        (sample_cnt_reg != 32'd0) |-> (min_reg <= 16'(max_reg)))
        else $error("minimum above maximum");

endmodule

@@ sim/supply_voltage_monitor_tb.sv @@
module supply_voltage_monitor_tb
    import svm_pkg::*;
();

    localparam int CYCLE_LIMIT = 600000;
    localparam int HOLD_CYCLES = 400;

    // One status report, split into its fields.
    typedef struct {
        logic        ok;
        logic [11:0] sample_out;
        logic [11:0] filtered;
        logic [15:0] pin_mv;
        logic [31:0] bat_mv;
        logic [31:0] samples;
        logic [31:0] timeouts;
        logic [15:0] lowest;
        logic [11:0] highest;
    } status_report_t;

    // Tracks the monitor state, predicts each report and checks the reports that come out.
    class report_checker;
        logic [REF_W-1:0]  ref_mv;
        logic [FS_W-1:0]   full_scale;
        logic [OHM_W-1:0]  top_ohms;
        logic [OHM_W-1:0]  bottom_ohms;
        logic [ACC_W-1:0]  acc;
        logic [15:0]       lowest;
        logic [11:0]       highest;
        logic [31:0]       samples;
        logic [31:0]       timeouts;
        logic [15:0]       pin_mv;
        logic [31:0]       bat_mv;
        logic [11:0]       filtered;
        status_report_t    expected_reports[$];
        int                failures;

        function new();
            ref_mv      = RESET_REF_MV;
            full_scale  = RESET_FS;
            top_ohms    = RESET_TOP;
            bottom_ohms = RESET_BOTTOM;
            acc         = '0;
            lowest      = 16'hFFFF;
            highest     = '0;
            samples     = '0;
            timeouts    = '0;
            pin_mv      = '0;
            bat_mv      = '0;
            filtered    = '0;
            failures    = 0;
        endfunction

        // Register values are cut to the width of each register.
        function void write_reg(logic [1:0] idx, logic [CFG_W-1:0] value);
            case (idx)
                REG_REFERENCE_MV: ref_mv      = value[REF_W-1:0];
                REG_FULL_SCALE:   full_scale  = value[FS_W-1:0];
                REG_DIV_TOP:      top_ohms    = value[OHM_W-1:0];
                REG_DIV_BOTTOM:   bottom_ohms = value[OHM_W-1:0];
                default:          ;
            endcase
        endfunction

        // Applies one accepted word to the state and queues the report it causes.
        function void note_event(logic func, logic [11:0] raw);
            logic [ACC_W-1:0] target;
            logic [63:0]      fs;
            logic [63:0]      bot;
            logic [63:0]      num;
            logic [63:0]      den;
            logic [63:0]      quo;
            status_report_t   rep;
            if (func == FUNC_TIMEOUT)
            begin
                timeouts = timeouts + 1;
            end
            else
            begin
                target = {raw, 8'd0};
                if (samples == 0)
                begin
                    // The first sample seeds the filter and the min/max tracking.
                    acc     = target;
                    lowest  = {4'd0, raw};
                    highest = raw;
                end
                else
                begin
                    // The error is divided by eight with truncation toward zero.
                    if (target >= acc)
                        acc = acc + ((target - acc) >> FILTER_SHIFT);
                    else
                        acc = acc - ((acc - target) >> FILTER_SHIFT);
                    if ({4'd0, raw} < lowest)
                        lowest = {4'd0, raw};
                    if (raw > highest)
                        highest = raw;
                end
                filtered = 12'((acc + 20'd128) >> 8);
                samples  = samples + 1;

                // A zero full scale or a zero bottom resistor counts as one.
                fs  = (full_scale == 0) ? 64'd1 : 64'(full_scale);
                bot = (bottom_ohms == 0) ? 64'd1 : 64'(bottom_ohms);
                num = 64'(filtered) * 64'(ref_mv) + fs / 2;
                quo = num / fs;
                pin_mv = quo[15:0];
                num = 64'(filtered) * 64'(ref_mv) * (64'(top_ohms) + bot);
                den = fs * bot;
                quo = (num + den / 2) / den;
                bat_mv = quo[31:0];
            end
            rep.ok         = (func == FUNC_SAMPLE);
            rep.sample_out = (func == FUNC_SAMPLE) ? raw : 12'd0;
            rep.filtered   = filtered;
            rep.pin_mv     = pin_mv;
            rep.bat_mv     = bat_mv;
            rep.samples    = samples;
            rep.timeouts   = timeouts;
            rep.lowest     = lowest;
            rep.highest    = highest;
            expected_reports.push_back(rep);
        endfunction

        function bit field_ok(string name, logic [31:0] exp_v, logic [31:0] act_v);
            if (exp_v === act_v)
                return 1'b1;
            if (failures < 10)
                $display("mismatch in %s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
            return 1'b0;
        endfunction

        // Compares one accepted report with the oldest prediction.
        function void check_report(logic ok, logic [167:0] data);
            status_report_t exp_r;
            bit             good;
            if (expected_reports.size() == 0)
            begin
                if (failures < 10)
                    $display("report with no prediction waiting: ok=%b data=0x%0h", ok, data);
                failures++;
                return;
            end
            exp_r = expected_reports.pop_front();
            good = 1'b1;
            good &= field_ok("ok", 32'(exp_r.ok), 32'(ok));
            good &= field_ok("sample_out", 32'(exp_r.sample_out), 32'(data[11:0]));
            good &= field_ok("filtered_value", 32'(exp_r.filtered), 32'(data[23:12]));
            good &= field_ok("pin_millivolts", 32'(exp_r.pin_mv), 32'(data[39:24]));
            good &= field_ok("battery_millivolts", exp_r.bat_mv, data[71:40]);
            good &= field_ok("samples_taken", exp_r.samples, data[103:72]);
            good &= field_ok("timeouts_seen", exp_r.timeouts, data[135:104]);
            good &= field_ok("lowest_raw", 32'(exp_r.lowest), 32'(data[151:136]));
            good &= field_ok("highest_raw", 32'(exp_r.highest), 32'(data[163:152]));
            if (!good)
                failures++;
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               s_tvalid;
    logic               s_tready;
    logic [15:0]        s_tdata;    // [11:0] raw_sample
    logic               s_tuser;    // [0] func
    logic               m_tvalid;
    logic               m_tready;
    logic [167:0]       m_tdata;    // [11:0] sample_out ... [163:152] highest_raw
    logic               m_tuser;    // [0] ok
    logic               cfg_we;
    logic [1:0]         cfg_index;
    logic [CFG_W-1:0]   cfg_wdata;

    report_checker reports;
    bit            hold_request;
    bit            quiet;
    int            cycle_count;

    supply_voltage_monitor uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #5 clk = ~clk;

    // Run limit.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Every accepted report goes to the checker.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            reports.check_report(m_tuser, m_tdata);
    end

    // The receiver stalls in random bursts, once for a long stretch on request.
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_request = 1'b0;
            end
            else if (!quiet && $urandom_range(0, 9) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    // Offers one word and waits until it is taken; valid stays high for the caller.
    task automatic send_word(input logic func, input logic [11:0] raw);
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= {4'd0, raw};
        do
            @(posedge clk);
        while (!s_tready);
        reports.note_event(func, raw);
    endtask

    task automatic sender_gap();
        if (!quiet && $urandom_range(0, 4) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    // Waits with the input idle until every predicted report has arrived.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (reports.expected_reports.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic put_reg(input logic [1:0] idx, input logic [CFG_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        reports.write_reg(idx, value);
    endtask

    task automatic configure(input logic [CFG_W-1:0] ref_v, input logic [CFG_W-1:0] fs_v,
                             input logic [CFG_W-1:0] top_v, input logic [CFG_W-1:0] bot_v);
        drain();
        put_reg(REG_REFERENCE_MV, ref_v);
        put_reg(REG_FULL_SCALE, fs_v);
        put_reg(REG_DIV_TOP, top_v);
        put_reg(REG_DIV_BOTTOM, bot_v);
        cfg_we <= 1'b0;
    endtask

    // Raw values lean toward the extremes and toward the current filter output,
    // where the error is small and truncation matters.
    function automatic logic [11:0] pick_raw();
        logic [11:0] raw;
        case ($urandom_range(0, 7))
            0:       raw = 12'h000;
            1:       raw = 12'hFFF;
            2, 3:    raw = reports.filtered ^ 12'($urandom_range(0, 15));
            default: raw = 12'($urandom);
        endcase
        return raw;
    endfunction

    task automatic random_words(input int count, input bit allow_gaps);
        logic func;
        for (int i = 0; i < count; i++)
        begin
            func = ($urandom_range(0, 4) == 0) ? FUNC_TIMEOUT : FUNC_SAMPLE;
            send_word(func, pick_raw());
            if (allow_gaps)
                sender_gap();
        end
    endtask

    initial
    begin
        reports      = new();
        clk          = 1'b0;
        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = 1'b0;
        m_tready     = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = '0;
        cfg_wdata    = '0;
        hold_request = 1'b0;
        quiet        = 1'b0;
        cycle_count  = 0;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed words at reset settings: timeouts before any sample, the seed,
        // full-scale swings, alternating bit patterns, and convergence on one value.
        send_word(FUNC_TIMEOUT, 12'hFFF);
        send_word(FUNC_TIMEOUT, 12'h000);
        send_word(FUNC_SAMPLE, 12'hFFF);
        send_word(FUNC_SAMPLE, 12'h000);
        sender_gap();
        send_word(FUNC_SAMPLE, 12'h000);
        send_word(FUNC_SAMPLE, 12'hAAA);
        send_word(FUNC_SAMPLE, 12'h555);
        send_word(FUNC_TIMEOUT, 12'h555);
        send_word(FUNC_SAMPLE, 12'h001);
        send_word(FUNC_SAMPLE, 12'h800);
        for (int i = 0; i < 8; i++)
        begin
            send_word(FUNC_SAMPLE, 12'h7FF);
            sender_gap();
        end
        random_words(80, 1'b1);

        // Extreme settings: large reference, smallest full scale and bottom resistor.
        configure(20'd5000, 20'd1, 20'd1000000, 20'd1);
        send_word(FUNC_SAMPLE, 12'hFFF);
        send_word(FUNC_SAMPLE, 12'h000);
        random_words(80, 1'b1);

        // Opposite extremes: smallest reference, largest full scale, no top resistor.
        configure(20'd1, 20'd65535, 20'd0, 20'd1000000);
        random_words(80, 1'b1);

        // Zero full scale and zero bottom resistor; the reference write carries
        // bits above its width.
        configure(20'hFE000 | 20'd3300, 20'd0, 20'd100000, 20'd0);
        random_words(80, 1'b1);

        // Long receiver stall while words keep coming, then wait for all reports.
        drain();
        hold_request = 1'b1;
        random_words(40, 1'b0);
        drain();

        for (int k = 0; k < 4; k++)
        begin
            configure(20'($urandom_range(1, 5000)), 20'($urandom_range(1, 65535)),
                      20'($urandom_range(0, 1000000)), 20'($urandom_range(1, 1000000)));
            random_words(50, 1'b1);
        end

        // Last part at typical settings with no idling on either side.
        configure(20'd3300, 20'd4095, 20'd100000, 20'd10000);
        quiet = 1'b1;
        random_words(60, 1'b0);

        drain();
        repeat (100) @(posedge clk);
        if (reports.failures == 0 && reports.expected_reports.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

@@ supply_voltage_monitor.f @@
rtl/core/svm_pkg.sv
rtl/core/supply_voltage_monitor.sv
sim/supply_voltage_monitor_tb.sv
